FILE: hw/rtl/sorted_set_membership_macros.svh
// Assertion macros shared by the RTL of the sorted set membership block.
// They assume a clock named clk and an active-low reset named rst_n.
`ifndef SORTED_SET_MEMBERSHIP_MACROS_SVH
`define SORTED_SET_MEMBERSHIP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted set membership: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted set membership: next-cycle check failed");

`endif

FILE: hw/rtl/ssm_pkg.sv
`default_nettype none

package ssm_pkg;

  localparam int unsigned SSM_DEPTH       = 1024;
  localparam int unsigned SSM_VALUE_WIDTH = 32;
  localparam int unsigned IN_VALUE_W      = 32;

  typedef enum logic [1:0] {
    FN_CLEAR  = 2'd0,
    FN_APPEND = 2'd1,
    FN_FINISH = 2'd2,
    FN_QUERY  = 2'd3
  } ssm_func_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NRDY = 2'd1,
    ST_FULL = 2'd2
  } ssm_status_t;

  typedef struct packed {
    ssm_func_t               func;
    logic [IN_VALUE_W-1:0]   value;
  } in_word_t;

  typedef struct packed {
    logic        found;
    ssm_status_t status;
  } out_word_t;

  // Control that travels with a word from cell to cell.
  typedef struct packed {
    logic      valid;
    ssm_func_t func;
    logic      hit;
    logic      placed;
    logic      nrdy;
  } ssm_tok_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ssm_cell.sv
`default_nettype none

module ssm_cell import ssm_pkg::*; #(
  parameter int unsigned SW = SSM_VALUE_WIDTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          adv,
  input  wire ssm_tok_t      tok_i,
  input  wire logic [SW-1:0] val_i,
  output ssm_tok_t           tok_o,
  output logic [SW-1:0]      val_o
);

  logic          occ_r, occ_nxt;
  logic [SW-1:0] key_r, key_nxt;
  ssm_tok_t      tok_r, tok_nxt;
  logic [SW-1:0] val_r;

  always_comb begin
    occ_nxt = occ_r;
    key_nxt = key_r;
    tok_nxt = tok_i;
    if (tok_i.valid) begin
      unique case (tok_i.func)
        FN_CLEAR: begin
          occ_nxt = 1'b0;
        end
        FN_APPEND: begin
          if (!tok_i.placed && !occ_r) begin
            occ_nxt        = 1'b1;
            key_nxt        = val_i;
            tok_nxt.placed = 1'b1;
          end
        end
        FN_FINISH: begin
        end
        FN_QUERY: begin
          if (occ_r && (key_r == val_i)) begin
            tok_nxt.hit = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
      tok_r <= '0;
    end else if (adv) begin
      occ_r <= occ_nxt;
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      key_r <= key_nxt;
      val_r <= val_i;
    end
  end

  assign tok_o = tok_r;
  assign val_o = val_r;

endmodule

`default_nettype wire

FILE: hw/rtl/sorted_set_membership.sv
// Channel | Ports                          | Carries
// input   | in_valid, in_stall, in_data    | func and value of one word
// output  | out_valid, out_stall, out_data | found and status of one word
//
// Every word travels down a row of DEPTH cells, one cell per cycle in which the
// row advances, and leaves through an output register.
// A new word is taken in every cycle in which the row advances.
// The row advances as one; a stalled output register holds the whole row.
// Reset empties every cell, marks the table not ready and stalls the input.
`default_nettype none

module sorted_set_membership import ssm_pkg::*; #(
  parameter int unsigned DEPTH       = SSM_DEPTH,
  parameter int unsigned VALUE_WIDTH = SSM_VALUE_WIDTH
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_data
);

`include "sorted_set_membership_macros.svh"

  localparam int unsigned SW = (VALUE_WIDTH < IN_VALUE_W) ? VALUE_WIDTH : IN_VALUE_W;

  logic      adv;
  logic      ready_r;
  logic      out_valid_r;
  out_word_t out_data_r;
  ssm_tok_t  tok_w [DEPTH+1];
  logic [SW-1:0] val_w [DEPTH+1];
  ssm_tok_t  tail;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv || !rst_n;

  assign tok_w[0] = '{
    valid:  in_valid,
    func:   in_data.func,
    hit:    1'b0,
    placed: 1'b0,
    nrdy:   (in_data.func == FN_QUERY) && !ready_r
  };
  assign val_w[0] = in_data.value[SW-1:0];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    ssm_cell #(
      .SW(SW)
    ) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .adv  (adv),
      .tok_i(tok_w[g]),
      .val_i(val_w[g]),
      .tok_o(tok_w[g+1]),
      .val_o(val_w[g+1])
    );
  end

  assign tail = tok_w[DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && adv) begin
        unique case (in_data.func) inside
          FN_CLEAR, FN_APPEND: ready_r <= 1'b0;
          FN_FINISH:           ready_r <= 1'b1;
          FN_QUERY:            ready_r <= ready_r;
        endcase
      end
      if (adv) begin
        out_valid_r <= tail.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.found <= (tail.func == FN_QUERY) && tail.hit && !tail.nrdy;
      if (tail.nrdy) begin
        out_data_r.status <= ST_NRDY;
      end else if ((tail.func == FN_APPEND) && !tail.placed) begin
        out_data_r.status <= ST_FULL;
      end else begin
        out_data_r.status <= ST_OK;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SSM_ASSERT_NOW(a_nrdy_not_found, out_valid_r && (out_data_r.status == ST_NRDY), !out_data_r.found)
  `SSM_ASSERT_NOW(a_found_is_ok, out_valid_r && out_data_r.found, out_data_r.status == ST_OK)
  `SSM_ASSERT_NEXT(a_finish_sets_ready, in_valid && !in_stall && (in_data.func == FN_FINISH), ready_r)
  `SSM_ASSERT_NEXT(a_append_clears_ready, in_valid && !in_stall && (in_data.func == FN_APPEND), !ready_r)

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ssm_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;

  logic [IN_VALUE_W-1:0] member_tbl [SSM_DEPTH];
  int unsigned tbl_count = 0;
  bit tbl_ready = 1'b0;
  out_word_t expected_results[$];

  int fail_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int run_left = 0;
  bit run_level = 1'b0;

  sorted_set_membership dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[sorted_set_membership] ERROR");
      $finish;
    end
  end

  function automatic void sort_members();
    logic [IN_VALUE_W-1:0] key;
    int j;
    for (int i = 1; i < int'(tbl_count); i++) begin
      key = member_tbl[i];
      j = i;
      while (j > 0 && member_tbl[j-1] > key) begin
        member_tbl[j] = member_tbl[j-1];
        j--;
      end
      member_tbl[j] = key;
    end
  endfunction

  function automatic bit lookup_member(logic [IN_VALUE_W-1:0] v);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    if (tbl_count == 0) return 1'b0;
    if (member_tbl[0] == v || member_tbl[tbl_count-1] == v) return 1'b1;
    lo = 0;
    hi = tbl_count - 1;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if (member_tbl[mid] == v) return 1'b1;
      if (member_tbl[mid] < v) lo = mid;
      else hi = mid;
    end
    return 1'b0;
  endfunction

  function automatic out_word_t predict_membership(in_word_t w);
    out_word_t r;
    r.found = 1'b0;
    r.status = ST_OK;
    case (w.func)
      FN_CLEAR: begin
        tbl_count = 0;
        tbl_ready = 1'b0;
      end
      FN_APPEND: begin
        tbl_ready = 1'b0;
        if (tbl_count >= SSM_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          member_tbl[tbl_count] = w.value;
          tbl_count++;
        end
      end
      FN_FINISH: begin
        sort_members();
        tbl_ready = 1'b1;
      end
      default: begin
        if (!tbl_ready) r.status = ST_NRDY;
        else r.found = lookup_member(w.value);
      end
    endcase
    return r;
  endfunction

  function automatic logic [IN_VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h0000_0000;
          1: return 32'hffff_ffff;
          2: return 32'h8000_0000;
          default: return 32'h7fff_ffff;
        endcase
      end
      1: return $urandom_range(0, 15);
      2: return 32'h8000_0000 + $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [IN_VALUE_W-1:0] pick_query();
    logic [IN_VALUE_W-1:0] v;
    if (tbl_count != 0 && $urandom_range(0, 1) == 0) begin
      v = member_tbl[$urandom_range(0, tbl_count - 1)];
      case ($urandom_range(0, 3))
        0: v = v + 1;
        1: v = v - 1;
        default: ;
      endcase
      return v;
    end
    return pick_value();
  endfunction

  always @(posedge clk) begin : check_results
    out_word_t exp_word;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected word: found=%0b status=%0d", out_data.found, out_data.status);
      end else begin
        exp_word = expected_results.pop_front();
        if (out_data.found !== exp_word.found || out_data.status !== exp_word.status) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected found=%0b status=%0d, got found=%0b status=%0d",
                     exp_word.found, exp_word.status, out_data.found, out_data.status);
        end
      end
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(50, 400);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: begin
        if (run_left == 0) begin
          run_level = ~run_level;
          run_left = $urandom_range(1, 20);
        end else begin
          run_left--;
        end
        out_stall <= run_level;
      end
    endcase
  end

  task automatic send_word(input ssm_func_t f, input logic [IN_VALUE_W-1:0] v);
    in_word_t w;
    int gap;
    w.func = f;
    w.value = v;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(predict_membership(w));
    burst_left--;
  endtask

  task automatic wait_drained();
    burst_left = 0;
    if (expected_results.size() != 0) begin
      in_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clk);
    end
  endtask

  task automatic test_directed();
    send_word(FN_QUERY, 32'h0000_0000);
    send_word(FN_QUERY, 32'hffff_ffff);
    send_word(FN_FINISH, 32'h0000_0000);
    send_word(FN_QUERY, 32'h0000_0000);
    send_word(FN_QUERY, 32'hffff_ffff);
    send_word(FN_APPEND, 32'hffff_ffff);
    send_word(FN_APPEND, 32'h8000_0000);
    send_word(FN_APPEND, 32'h0000_0000);
    send_word(FN_APPEND, 32'h7fff_ffff);
    send_word(FN_APPEND, 32'h0000_0001);
    send_word(FN_QUERY, 32'h0000_0001);
    send_word(FN_FINISH, 32'hffff_ffff);
    send_word(FN_QUERY, 32'h0000_0000);
    send_word(FN_QUERY, 32'hffff_ffff);
    send_word(FN_QUERY, 32'h8000_0000);
    send_word(FN_QUERY, 32'h7fff_ffff);
    send_word(FN_QUERY, 32'h0000_0001);
    send_word(FN_QUERY, 32'h0000_0002);
    send_word(FN_QUERY, 32'h8000_0001);
    send_word(FN_FINISH, 32'h5555_5555);
    send_word(FN_QUERY, 32'h7fff_ffff);
    send_word(FN_APPEND, 32'h1234_5678);
    send_word(FN_QUERY, 32'h8000_0000);
    send_word(FN_CLEAR, 32'haaaa_aaaa);
    send_word(FN_QUERY, 32'h0000_0000);
  endtask

  task automatic test_fill_to_full();
    send_word(FN_CLEAR, $urandom);
    repeat (SSM_DEPTH) send_word(FN_APPEND, pick_value());
    repeat (3) send_word(FN_APPEND, $urandom);
    send_word(FN_QUERY, pick_query());
    send_word(FN_FINISH, $urandom);
    repeat (40) send_word(FN_QUERY, pick_query());
    send_word(FN_APPEND, $urandom);
    send_word(FN_QUERY, pick_query());
    send_word(FN_FINISH, $urandom);
    repeat (4) send_word(FN_QUERY, pick_query());
    send_word(FN_CLEAR, $urandom);
  endtask

  task automatic test_random_sets(input int n_items);
    int sent;
    int n_app;
    int n_qry;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 7) != 0) begin
        send_word(FN_CLEAR, $urandom);
        sent++;
      end
      n_app = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 96) : $urandom_range(0, 12);
      repeat (n_app) begin
        send_word(FN_APPEND, pick_value());
        sent++;
        if ($urandom_range(0, 15) == 0) begin
          send_word(FN_QUERY, pick_query());
          sent++;
        end
      end
      if ($urandom_range(0, 9) != 0) begin
        send_word(FN_FINISH, $urandom);
        sent++;
      end
      if ($urandom_range(0, 7) == 0) begin
        send_word(FN_FINISH, $urandom);
        sent++;
      end
      n_qry = $urandom_range(1, 16);
      repeat (n_qry) begin
        if ($urandom_range(0, 19) == 0) send_word(ssm_func_t'($urandom_range(0, 3)), $urandom);
        else send_word(FN_QUERY, pick_query());
        sent++;
      end
      if ($urandom_range(0, 150) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    wait_drained();
    test_fill_to_full();
    wait_drained();
    test_random_sets(470);
    wait_drained();
    repeat (SSM_DEPTH + 50) @(posedge clk);
    if (fail_count == 0) begin
      $display("[sorted_set_membership] OK");
    end else begin
      $display("[sorted_set_membership] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/ssm_pkg.sv
hw/rtl/ssm_cell.sv
hw/rtl/sorted_set_membership.sv
sim/tb_top.sv
